>>> design/hcb_pkg.sv
// Shared types, constants and codes of the Huffman code builder.
`default_nettype none
package hcb_pkg;

    localparam int SYM_BITS      = 8;
    localparam int ALPHA_SIZE    = 256;
    localparam int COUNT_BITS    = 16;
    localparam int WGT_BITS      = 24;
    localparam int NODE_BITS     = 9;
    localparam int NODE_DEPTH    = 2 * ALPHA_SIZE - 1;
    localparam int KID_DEPTH     = ALPHA_SIZE - 1;
    localparam int MAX_CODE_BITS = 32;
    localparam int LEN_BITS      = 6;
    localparam int WALK_BITS     = 8;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [1:0] OP_COUNT  = 2'd0;
    localparam logic [1:0] OP_BUILD  = 2'd1;
    localparam logic [1:0] OP_ENCODE = 2'd2;
    localparam logic [1:0] OP_DECODE = 2'd3;

    localparam logic [1:0] KIND_BUILD = 2'd0;
    localparam logic [1:0] KIND_CODE  = 2'd1;
    localparam logic [1:0] KIND_BYTE  = 2'd2;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_ABSENT = 2'd1;
    localparam logic [1:0] STAT_LONG   = 2'd2;
    localparam logic [1:0] STAT_EMPTY  = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CNT_RD, ST_CNT_WR, ST_ENC_RD, ST_ENC_OUT,
        ST_DEC_RD, ST_DEC_CHILD, ST_DEC_LRD, ST_DEC_OUT,
        ST_B_LRD, ST_B_LWR, ST_B_CHK, ST_M_SCAN, ST_M_W1, ST_M_W2, ST_M_W3,
        ST_C_START, ST_C_RD, ST_C_PAR, ST_C_KID, ST_C_STEP, ST_C_WR, ST_B_OUT
    } t_state;

    typedef enum logic [4:0] {
        UOP_IDLE, UOP_CNT_RD, UOP_CNT_WR, UOP_ENC_RD, UOP_ENC_OUT,
        UOP_DEC_RD, UOP_DEC_CHILD, UOP_DEC_LRD, UOP_DEC_OUT,
        UOP_B_LRD, UOP_B_LWR, UOP_B_CHK, UOP_M_SCAN, UOP_M_W1, UOP_M_W2, UOP_M_W3,
        UOP_C_START, UOP_C_RD, UOP_C_PAR, UOP_C_KID, UOP_C_STEP, UOP_C_WR, UOP_B_OUT
    } t_uop;

    typedef struct packed {
        t_uop uop;
        logic accept;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] op;
        logic       out_free;
        logic       leaf_last;
        logic       n_zero;
        logic       n_one;
        logic       scan_done;
        logic       merge_last;
        logic       has_parent;
        logic       code_last;
        logic       dec_emit;
    } t_sts;

endpackage
`default_nettype wire

>>> design/hcb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> design/hcb_ctrl.sv
// Sequencer of the Huffman code builder: item dispatch, build phases, result hand-off.
`default_nettype none
module hcb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire hcb_pkg::t_sts i_sts,
    output hcb_pkg::t_cmd      o_cmd,
    output logic               o_in_stall
);

    hcb_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hcb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.uop    = hcb_pkg::UOP_IDLE;
        o_cmd.accept = 1'b0;
        o_cmd.load   = 1'b0;
        case (r_state)
            hcb_pkg::ST_IDLE: begin
                o_cmd.accept = i_sts.in_valid;
                if (i_sts.in_valid) begin
                    case (i_sts.op)
                        hcb_pkg::OP_COUNT:  n_state = hcb_pkg::ST_CNT_RD;
                        hcb_pkg::OP_BUILD:  n_state = hcb_pkg::ST_B_LRD;
                        hcb_pkg::OP_ENCODE: n_state = hcb_pkg::ST_ENC_RD;
                        default:            n_state = hcb_pkg::ST_DEC_RD;
                    endcase
                end
            end
            hcb_pkg::ST_CNT_RD: begin
                o_cmd.uop = hcb_pkg::UOP_CNT_RD;
                n_state   = hcb_pkg::ST_CNT_WR;
            end
            hcb_pkg::ST_CNT_WR: begin
                o_cmd.uop = hcb_pkg::UOP_CNT_WR;
                n_state   = hcb_pkg::ST_IDLE;
            end
            hcb_pkg::ST_ENC_RD: begin
                o_cmd.uop = hcb_pkg::UOP_ENC_RD;
                n_state   = hcb_pkg::ST_ENC_OUT;
            end
            hcb_pkg::ST_ENC_OUT: begin
                o_cmd.uop  = hcb_pkg::UOP_ENC_OUT;
                o_cmd.load = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = hcb_pkg::ST_IDLE;
                end
            end
            hcb_pkg::ST_DEC_RD: begin
                o_cmd.uop = hcb_pkg::UOP_DEC_RD;
                n_state   = hcb_pkg::ST_DEC_CHILD;
            end
            hcb_pkg::ST_DEC_CHILD: begin
                o_cmd.uop = hcb_pkg::UOP_DEC_CHILD;
                n_state   = i_sts.dec_emit ? hcb_pkg::ST_DEC_LRD : hcb_pkg::ST_IDLE;
            end
            hcb_pkg::ST_DEC_LRD: begin
                o_cmd.uop = hcb_pkg::UOP_DEC_LRD;
                n_state   = hcb_pkg::ST_DEC_OUT;
            end
            hcb_pkg::ST_DEC_OUT: begin
                o_cmd.uop  = hcb_pkg::UOP_DEC_OUT;
                o_cmd.load = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = hcb_pkg::ST_IDLE;
                end
            end
            hcb_pkg::ST_B_LRD: begin
                o_cmd.uop = hcb_pkg::UOP_B_LRD;
                n_state   = hcb_pkg::ST_B_LWR;
            end
            hcb_pkg::ST_B_LWR: begin
                o_cmd.uop = hcb_pkg::UOP_B_LWR;
                n_state   = i_sts.leaf_last ? hcb_pkg::ST_B_CHK : hcb_pkg::ST_B_LRD;
            end
            hcb_pkg::ST_B_CHK: begin
                o_cmd.uop = hcb_pkg::UOP_B_CHK;
                if (i_sts.n_zero) begin
                    n_state = hcb_pkg::ST_B_OUT;
                end else if (i_sts.n_one) begin
                    n_state = hcb_pkg::ST_C_START;
                end else begin
                    n_state = hcb_pkg::ST_M_SCAN;
                end
            end
            hcb_pkg::ST_M_SCAN: begin
                o_cmd.uop = hcb_pkg::UOP_M_SCAN;
                if (i_sts.scan_done) begin
                    n_state = hcb_pkg::ST_M_W1;
                end
            end
            hcb_pkg::ST_M_W1: begin
                o_cmd.uop = hcb_pkg::UOP_M_W1;
                n_state   = hcb_pkg::ST_M_W2;
            end
            hcb_pkg::ST_M_W2: begin
                o_cmd.uop = hcb_pkg::UOP_M_W2;
                n_state   = hcb_pkg::ST_M_W3;
            end
            hcb_pkg::ST_M_W3: begin
                o_cmd.uop = hcb_pkg::UOP_M_W3;
                n_state   = i_sts.merge_last ? hcb_pkg::ST_C_START : hcb_pkg::ST_M_SCAN;
            end
            hcb_pkg::ST_C_START: begin
                o_cmd.uop = hcb_pkg::UOP_C_START;
                n_state   = hcb_pkg::ST_C_RD;
            end
            hcb_pkg::ST_C_RD: begin
                o_cmd.uop = hcb_pkg::UOP_C_RD;
                n_state   = hcb_pkg::ST_C_PAR;
            end
            hcb_pkg::ST_C_PAR: begin
                o_cmd.uop = hcb_pkg::UOP_C_PAR;
                n_state   = i_sts.has_parent ? hcb_pkg::ST_C_KID : hcb_pkg::ST_C_WR;
            end
            hcb_pkg::ST_C_KID: begin
                o_cmd.uop = hcb_pkg::UOP_C_KID;
                n_state   = hcb_pkg::ST_C_STEP;
            end
            hcb_pkg::ST_C_STEP: begin
                o_cmd.uop = hcb_pkg::UOP_C_STEP;
                n_state   = hcb_pkg::ST_C_RD;
            end
            hcb_pkg::ST_C_WR: begin
                o_cmd.uop = hcb_pkg::UOP_C_WR;
                n_state   = i_sts.code_last ? hcb_pkg::ST_B_OUT : hcb_pkg::ST_C_START;
            end
            hcb_pkg::ST_B_OUT: begin
                o_cmd.uop  = hcb_pkg::UOP_B_OUT;
                o_cmd.load = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = hcb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hcb_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != hcb_pkg::ST_IDLE);

endmodule
`default_nettype wire

>>> design/hcb_dpath.sv
// Datapath of the Huffman code builder: tables, merge scan, code walk, result register.
`default_nettype none
module hcb_dpath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire hcb_pkg::t_cmd i_cmd,
    output hcb_pkg::t_sts      o_sts,
    input  wire logic          i_in_valid,
    input  wire logic [1:0]    i_op,
    input  wire logic [7:0]    i_symbol,
    input  wire logic          i_code_bit,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_decoded_symbol,
    output logic [31:0]        o_code_word,
    output logic [5:0]         o_code_length,
    output logic [1:0]         o_status
);

    localparam int NB = hcb_pkg::NODE_BITS;
    localparam int SB = hcb_pkg::SYM_BITS;
    localparam int WB = hcb_pkg::WGT_BITS;
    localparam int CB = hcb_pkg::COUNT_BITS;
    localparam int LB = hcb_pkg::LEN_BITS;
    localparam int XB = hcb_pkg::WALK_BITS;
    localparam int MB = hcb_pkg::MAX_CODE_BITS;

    logic [SB-1:0]         r_sym;
    logic                  r_bit;
    logic [hcb_pkg::ALPHA_SIZE-1:0] r_hvld;
    logic                  r_built;
    logic [NB-1:0]         r_n, r_dn, r_i, r_j, r_pidx, r_mi, r_si, r_now, r_p;
    logic [SB-1:0]         r_m, r_child;
    logic                  r_pv, r_mv, r_sv, r_long;
    logic [WB-1:0]         r_wm, r_ws;
    logic [XB-1:0]         r_len;
    logic [MB-1:0]         r_code;
    logic [1:0]            r_bstat, r_dstat;
    logic                  r_out_valid;
    logic [1:0]            r_kind, r_status;
    logic [SB-1:0]         r_dsym;
    logic [MB-1:0]         r_word;
    logic [LB-1:0]         r_olen;

    // memory ports
    logic [CB-1:0]       hist_rd;
    logic                hist_we;
    logic [SB-1:0]       hist_raddr;
    logic [WB:0]         wgt_rd, wgt_wd;
    logic                wgt_we;
    logic [NB-1:0]       wgt_waddr, wgt_raddr;
    logic [NB-1:0]       par_rd, par_wd, par_waddr;
    logic                par_we;
    logic [2*NB-1:0]     kid_rd;
    logic                kid_we;
    logic [SB-1:0]       kid_raddr;
    logic [SB-1:0]       lsym_rd, lsym_raddr;
    logic                lsym_we;
    logic [LB+MB-1:0]    code_rd;
    logic                code_we;

    logic [SB-1:0]  w_hidx;
    logic [CB-1:0]  w_hval, w_hinc;
    logic           w_hpres;
    logic [NB:0]    w_root_x;
    logic [NB-1:0]  w_root, w_nm, w_dn_fix, w_k, w_pk, w_child;
    logic           w_out_free, w_dec_fail, w_dec_one, w_dec_leaf;
    logic [LB-1:0]  w_len6;
    logic           w_len_long;

    assign w_out_free = !r_out_valid || !i_out_stall;

    // a byte is present after a build while its histogram entry is nonzero
    assign w_hidx  = (i_cmd.uop == hcb_pkg::UOP_B_LRD || i_cmd.uop == hcb_pkg::UOP_B_LWR)
                     ? r_i[SB-1:0] : r_sym;
    assign hist_raddr = w_hidx;
    assign w_hval  = r_hvld[w_hidx] ? hist_rd : '0;
    assign w_hinc  = (w_hval == hcb_pkg::COUNT_MAX) ? w_hval : w_hval + 1'b1;
    assign w_hpres = (w_hval != '0);
    assign hist_we = (i_cmd.uop == hcb_pkg::UOP_CNT_WR);

    assign w_root_x = {r_n, 1'b0} - (NB+1)'(2);
    assign w_root   = w_root_x[NB-1:0];
    assign w_nm     = r_n + NB'(r_m);
    assign w_dn_fix = (r_dn < r_n || r_dn > w_root) ? w_root : r_dn;
    assign w_k      = w_dn_fix - r_n;
    assign w_pk     = r_p - r_n;
    assign w_child  = r_bit ? kid_rd[NB-1:0] : kid_rd[2*NB-1:NB];

    assign w_dec_fail = !r_built || (r_n == '0);
    assign w_dec_one  = (r_n == NB'(1));
    assign w_dec_leaf = (w_child < r_n);

    assign w_len_long = (r_len > XB'(MB));
    assign w_len6     = w_len_long ? LB'(MB + 1) : r_len[LB-1:0];

    // address and write selection per micro-op
    always_comb begin
        wgt_we    = 1'b0;
        wgt_waddr = r_n;
        wgt_wd    = {1'b0, WB'(w_hval)};
        par_we    = 1'b0;
        par_waddr = r_mi;
        par_wd    = w_nm;
        kid_we    = 1'b0;
        lsym_we   = 1'b0;
        code_we   = 1'b0;
        case (i_cmd.uop)
            hcb_pkg::UOP_B_LWR: begin
                wgt_we  = w_hpres;
                lsym_we = w_hpres;
            end
            hcb_pkg::UOP_M_W1: begin
                wgt_we    = 1'b1;
                wgt_waddr = w_nm;
                wgt_wd    = {1'b0, r_wm + r_ws};
                par_we    = 1'b1;
                kid_we    = 1'b1;
            end
            hcb_pkg::UOP_M_W2: begin
                wgt_we    = 1'b1;
                wgt_waddr = r_mi;
                wgt_wd    = {1'b1, r_wm};
                par_we    = 1'b1;
                par_waddr = r_si;
            end
            hcb_pkg::UOP_M_W3: begin
                wgt_we    = 1'b1;
                wgt_waddr = r_si;
                wgt_wd    = {1'b1, r_ws};
            end
            hcb_pkg::UOP_C_WR: begin
                code_we = 1'b1;
            end
            default: begin
                wgt_we = 1'b0;
            end
        endcase
    end

    assign wgt_raddr  = (i_cmd.uop == hcb_pkg::UOP_M_SCAN) ? r_j : r_now;
    assign kid_raddr  = (i_cmd.uop == hcb_pkg::UOP_DEC_RD) ? w_k[SB-1:0] : w_pk[SB-1:0];
    assign lsym_raddr = (i_cmd.uop == hcb_pkg::UOP_DEC_LRD || i_cmd.uop == hcb_pkg::UOP_DEC_OUT)
                        ? r_child : r_i[SB-1:0];

    hcb_ram #(.WIDTH(CB), .DEPTH(hcb_pkg::ALPHA_SIZE)) u_hist (
        .i_clk(i_clk), .i_we(hist_we), .i_waddr(r_sym), .i_wdata(w_hinc),
        .i_raddr(hist_raddr), .o_rdata(hist_rd)
    );

    hcb_ram #(.WIDTH(WB + 1), .DEPTH(hcb_pkg::NODE_DEPTH)) u_wgt (
        .i_clk(i_clk), .i_we(wgt_we), .i_waddr(wgt_waddr), .i_wdata(wgt_wd),
        .i_raddr(wgt_raddr), .o_rdata(wgt_rd)
    );

    hcb_ram #(.WIDTH(NB), .DEPTH(hcb_pkg::NODE_DEPTH)) u_par (
        .i_clk(i_clk), .i_we(par_we), .i_waddr(par_waddr), .i_wdata(par_wd),
        .i_raddr(r_now), .o_rdata(par_rd)
    );

    hcb_ram #(.WIDTH(2 * NB), .DEPTH(hcb_pkg::KID_DEPTH)) u_kid (
        .i_clk(i_clk), .i_we(kid_we), .i_waddr(r_m), .i_wdata({r_mi, r_si}),
        .i_raddr(kid_raddr), .o_rdata(kid_rd)
    );

    hcb_ram #(.WIDTH(SB), .DEPTH(hcb_pkg::ALPHA_SIZE)) u_lsym (
        .i_clk(i_clk), .i_we(lsym_we), .i_waddr(r_n[SB-1:0]), .i_wdata(r_i[SB-1:0]),
        .i_raddr(lsym_raddr), .o_rdata(lsym_rd)
    );

    hcb_ram #(.WIDTH(LB + MB), .DEPTH(hcb_pkg::ALPHA_SIZE)) u_code (
        .i_clk(i_clk), .i_we(code_we), .i_waddr(lsym_rd), .i_wdata({w_len6, r_code}),
        .i_raddr(r_sym), .o_rdata(code_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvld      <= '0;
            r_built     <= 1'b0;
            r_n         <= '0;
            r_dn        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.uop)
                hcb_pkg::UOP_IDLE: begin
                    if (i_cmd.accept) begin
                        r_sym <= i_symbol;
                        r_bit <= i_code_bit;
                        if (i_op == hcb_pkg::OP_COUNT && r_built) begin
                            // drop the old tree and start a fresh histogram
                            r_hvld  <= '0;
                            r_built <= 1'b0;
                            r_n     <= '0;
                            r_dn    <= '0;
                        end
                        if (i_op == hcb_pkg::OP_BUILD) begin
                            r_i     <= '0;
                            r_n     <= '0;
                            r_built <= 1'b1;
                        end
                    end
                end
                hcb_pkg::UOP_CNT_WR: begin
                    r_hvld[r_sym] <= 1'b1;
                end
                hcb_pkg::UOP_B_LWR: begin
                    if (w_hpres) begin
                        r_n <= r_n + 1'b1;
                    end
                    r_i <= r_i + 1'b1;
                end
                hcb_pkg::UOP_B_CHK: begin
                    r_m    <= '0;
                    r_i    <= '0;
                    r_long <= 1'b0;
                    r_j    <= '0;
                    r_pv   <= 1'b0;
                    r_mv   <= 1'b0;
                    r_sv   <= 1'b0;
                    if (r_n == '0) begin
                        r_dn    <= '0;
                        r_bstat <= hcb_pkg::STAT_EMPTY;
                    end
                end
                hcb_pkg::UOP_M_SCAN: begin
                    if (r_pv && !wgt_rd[WB]) begin
                        if (!r_mv || wgt_rd[WB-1:0] < r_wm) begin
                            r_si <= r_mi;
                            r_ws <= r_wm;
                            r_sv <= r_mv;
                            r_mi <= r_pidx;
                            r_wm <= wgt_rd[WB-1:0];
                            r_mv <= 1'b1;
                        end else if (!r_sv || wgt_rd[WB-1:0] < r_ws) begin
                            r_si <= r_pidx;
                            r_ws <= wgt_rd[WB-1:0];
                            r_sv <= 1'b1;
                        end
                    end
                    if (r_j != w_nm) begin
                        r_pidx <= r_j;
                        r_pv   <= 1'b1;
                        r_j    <= r_j + 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                end
                hcb_pkg::UOP_M_W3: begin
                    r_m  <= r_m + 1'b1;
                    r_j  <= '0;
                    r_pv <= 1'b0;
                    r_mv <= 1'b0;
                    r_sv <= 1'b0;
                end
                hcb_pkg::UOP_C_START: begin
                    r_now  <= r_i;
                    r_len  <= '0;
                    r_code <= '0;
                end
                hcb_pkg::UOP_C_PAR: begin
                    r_p <= par_rd;
                end
                hcb_pkg::UOP_C_STEP: begin
                    if (kid_rd[NB-1:0] == r_now && r_len < XB'(MB)) begin
                        r_code[r_len[$clog2(MB)-1:0]] <= 1'b1;
                    end
                    r_len <= r_len + 1'b1;
                    r_now <= r_p;
                end
                hcb_pkg::UOP_C_WR: begin
                    r_long <= r_long || w_len_long;
                    r_i    <= r_i + 1'b1;
                    if (r_i + 1'b1 == r_n) begin
                        r_dn    <= w_root;
                        r_bstat <= (r_long || w_len_long) ? hcb_pkg::STAT_LONG
                                                          : hcb_pkg::STAT_OK;
                    end
                end
                hcb_pkg::UOP_DEC_RD: begin
                    if (!w_dec_fail && !w_dec_one) begin
                        r_dn <= w_dn_fix;
                    end
                end
                hcb_pkg::UOP_DEC_CHILD: begin
                    r_child <= '0;
                    r_dstat <= hcb_pkg::STAT_OK;
                    if (w_dec_fail) begin
                        r_dstat <= hcb_pkg::STAT_ABSENT;
                    end else if (!w_dec_one) begin
                        if (w_dec_leaf) begin
                            r_child <= w_child[SB-1:0];
                            r_dn    <= w_root;
                        end else begin
                            r_dn <= w_child;
                        end
                    end
                end
                default: begin
                    r_built <= r_built;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dsym <= '0;
            r_word <= '0;
            r_olen <= '0;
            case (i_cmd.uop)
                hcb_pkg::UOP_ENC_OUT: begin
                    r_kind <= hcb_pkg::KIND_CODE;
                    if (!r_built || !w_hpres) begin
                        r_status <= hcb_pkg::STAT_ABSENT;
                    end else if (code_rd[LB+MB-1:MB] > LB'(MB)) begin
                        r_status <= hcb_pkg::STAT_LONG;
                    end else begin
                        r_status <= hcb_pkg::STAT_OK;
                        r_word   <= code_rd[MB-1:0];
                        r_olen   <= code_rd[LB+MB-1:MB];
                    end
                end
                hcb_pkg::UOP_DEC_OUT: begin
                    r_kind   <= hcb_pkg::KIND_BYTE;
                    r_status <= r_dstat;
                    if (r_dstat == hcb_pkg::STAT_OK) begin
                        r_dsym <= lsym_rd;
                    end
                end
                default: begin
                    r_kind   <= hcb_pkg::KIND_BUILD;
                    r_status <= r_bstat;
                end
            endcase
        end
    end

    always_comb begin
        o_sts.in_valid   = i_in_valid;
        o_sts.op         = i_op;
        o_sts.out_free   = w_out_free;
        o_sts.leaf_last  = (r_i[SB-1:0] == SB'(hcb_pkg::ALPHA_SIZE - 1));
        o_sts.n_zero     = (r_n == '0);
        o_sts.n_one      = (r_n == NB'(1));
        o_sts.scan_done  = (r_j == w_nm) && !r_pv;
        o_sts.merge_last = (NB'(r_m) + NB'(2) == r_n);
        o_sts.has_parent = wgt_rd[WB];
        o_sts.code_last  = (r_i + 1'b1 == r_n);
        o_sts.dec_emit   = w_dec_fail || w_dec_one || w_dec_leaf;
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_decoded_symbol = r_dsym;
    assign o_code_word      = r_word;
    assign o_code_length    = r_olen;
    assign o_status         = r_status;

endmodule
`default_nettype wire

>>> design/huffman_code_builder.sv
// Top level of the Huffman code builder: sequencer plus datapath.
//
// Items are taken one at a time. A count item is accepted, reads its
// histogram entry and writes it back with a saturating increment. An
// encode item and a decode bit are bound by the registered reads of the
// code, child and leaf tables; a decode bit goes on to the leaf table and
// gives a result only when it reaches a leaf or finds no tree. A build
// item walks all 256 histogram entries, then for each of the n-1 merges
// scans the n+m nodes built so far once through the node weight memory,
// bound by its single read port, and writes back the new node in three
// write steps, then walks every leaf up to the root, one level at a time,
// to form its code. Results leave through an output register; the block
// takes the next item while the last result waits, and holds a
// result-producing item until that register frees up.
`default_nettype none
module huffman_code_builder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [7:0]  i_symbol,
    input  wire logic        i_code_bit,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_decoded_symbol,
    output logic [31:0]      o_code_word,
    output logic [5:0]       o_code_length,
    output logic [1:0]       o_status
);

    hcb_pkg::t_cmd cmd;
    hcb_pkg::t_sts sts;

    // sequence every item and build phase
    hcb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // hold the tables and the result register
    hcb_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_in_valid       (i_in_valid),
        .i_op             (i_op),
        .i_symbol         (i_symbol),
        .i_code_bit       (i_code_bit),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_kind           (o_kind),
        .o_decoded_symbol (o_decoded_symbol),
        .o_code_word      (o_code_word),
        .o_code_length    (o_code_length),
        .o_status         (o_status)
    );

endmodule
`default_nettype wire
